// ===== rtl/psfp_pkg.sv =====
// Shared types and constants for the particle sensor frame parser.
package psfp_pkg;

    // Payload bytes kept in the store.
    localparam int PAYLOAD_BYTES = 24;

    // Frame start bytes.
    localparam logic [7:0] START_BYTE_A = 8'h42;
    localparam logic [7:0] START_BYTE_B = 8'h4D;

    // Accepted values of the length field (low byte; the high byte must be zero).
    localparam logic [7:0] LEN_SHORT = 8'(2 * 9 + 2);
    localparam logic [7:0] LEN_LONG  = 8'(2 * 13 + 2);

    // Byte position within a frame.
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_START_A  = 5'd0;
    localparam logic [POS_W-1:0] POS_START_B  = 5'd1;
    localparam logic [POS_W-1:0] POS_LEN_HI   = 5'd2;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 5'd3;
    localparam logic [POS_W-1:0] POS_PAYLOAD  = 5'd4;
    localparam logic [POS_W-1:0] POS_CK_HI_SHORT = 5'(2 * 9 + 2 + 2);
    localparam logic [POS_W-1:0] POS_CK_HI_LONG  = 5'(2 * 13 + 2 + 2);

    // Result field widths.
    localparam int WORD_IDX_W = 4;
    localparam int WORD_VAL_W = 16;

    // Controller states.
    typedef enum logic [1:0] {
        ST_RX,
        ST_FETCH,
        ST_SHOW,
        ST_ERR
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic byte_accept;
        logic word_clear;
        logic word_inc;
        logic fetch;
        logic err_sel;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_end;
        logic sum_match;
        logic last_word;
    } status_t;

    // One result beat.
    typedef struct packed {
        logic [WORD_IDX_W-1:0] word_index;
        logic [WORD_VAL_W-1:0] word_value;
        logic                  frame_ok;
        logic                  last;
    } result_t;

endpackage

// ===== rtl/psfp_byte_if.sv =====
// Valid/ready channel that carries one received serial byte per beat.
interface psfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/psfp_word_if.sv =====
// Valid/ready channel that carries one measurement word or error item per beat.
interface psfp_word_if;
    logic        valid;
    logic        ready;
    logic [3:0]  word_index;
    logic [15:0] word_value;
    logic        frame_ok;
    logic        last;

    modport source (output valid, output word_index, output word_value,
                    output frame_ok, output last, input ready);
    modport sink   (input valid, input word_index, input word_value,
                    input frame_ok, input last, output ready);
endinterface

// ===== rtl/psfp_ctrl.sv =====
// Controller state machine: byte reception, word read-out and error beat.
module psfp_ctrl
    import psfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RX;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_RX:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.byte_accept = 1'b1;
                    if (status.frame_end)
                    begin
                        if (status.sum_match)
                        begin
                            cmd.word_clear = 1'b1;
                            state_next     = ST_FETCH;
                        end
                        else
                        begin
                            state_next = ST_ERR;
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.last_word)
                    begin
                        state_next = ST_RX;
                    end
                    else
                    begin
                        cmd.word_inc = 1'b1;
                        state_next   = ST_FETCH;
                    end
                end
            end
            ST_ERR:
            begin
                out_valid   = 1'b1;
                cmd.err_sel = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_RX;
                end
            end
            default:
            begin
                state_next = ST_RX;
            end
        endcase
    end

endmodule

// ===== rtl/psfp_datapath.sv =====
// Datapath: frame position, checksum sum, payload store and result formatting.
module psfp_datapath
    import psfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  cmd_t       cmd,
    output status_t    status,
    output result_t    res
);

    localparam int WORD_COUNT = PAYLOAD_BYTES / 2;
    localparam int WORD_W     = $clog2(WORD_COUNT);

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [15:0]       sum_reg;
    logic [15:0]       sum_next;
    logic [7:0]        len_hi_reg;
    logic [7:0]        len_hi_next;
    logic              long_reg;
    logic              long_next;
    logic [7:0]        ck_hi_reg;
    logic [7:0]        ck_hi_next;

    logic [15:0]       sum_plus;
    logic [POS_W-1:0]  ck_hi_pos;
    logic [POS_W-1:0]  ck_lo_pos;
    logic [POS_W-1:0]  pidx;
    logic              store_we;
    logic [WORD_W-1:0] store_addr;

    // Payload store: even and odd bytes in separate banks, one word per entry.
    logic [7:0]            even_mem_reg [WORD_COUNT];
    logic [7:0]            odd_mem_reg  [WORD_COUNT];
    logic [WORD_COUNT-1:0] even_vld_reg;
    logic [WORD_COUNT-1:0] odd_vld_reg;
    logic [7:0]            even_rd_reg;
    logic [7:0]            odd_rd_reg;
    logic                  even_rd_vld_reg;
    logic                  odd_rd_vld_reg;
    logic [WORD_W-1:0]     word_reg;

    assign sum_plus  = sum_reg + {8'h00, rx_byte};
    assign ck_hi_pos = long_reg ? POS_CK_HI_LONG : POS_CK_HI_SHORT;
    assign ck_lo_pos = ck_hi_pos + 5'd1;
    assign pidx      = pos_reg - POS_PAYLOAD;
    assign store_addr = pidx[1 +: WORD_W];

    // Per-byte frame parsing and controller status.
    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        len_hi_next = len_hi_reg;
        long_next   = long_reg;
        ck_hi_next  = ck_hi_reg;
        store_we    = 1'b0;
        status.frame_end = 1'b0;
        status.sum_match = (sum_reg == {ck_hi_reg, rx_byte});
        status.last_word = (word_reg == WORD_W'(WORD_COUNT - 1));
        unique case (pos_reg)
            POS_START_A:
            begin
                if (rx_byte == START_BYTE_A)
                begin
                    sum_next = {8'h00, rx_byte};
                    pos_next = POS_START_B;
                end
            end
            POS_START_B:
            begin
                if (rx_byte == START_BYTE_B)
                begin
                    sum_next = sum_plus;
                    pos_next = POS_LEN_HI;
                end
                else
                begin
                    pos_next = POS_START_A;
                end
            end
            POS_LEN_HI:
            begin
                sum_next    = sum_plus;
                len_hi_next = rx_byte;
                pos_next    = POS_LEN_LO;
            end
            POS_LEN_LO:
            begin
                // The length is accepted only when the high byte is zero and the low byte is a known value.
                if ((len_hi_reg == 8'h00)
                    && ((rx_byte == LEN_SHORT) || (rx_byte == LEN_LONG)))
                begin
                    long_next = (rx_byte == LEN_LONG);
                    sum_next  = sum_plus;
                    pos_next  = POS_PAYLOAD;
                end
                else
                begin
                    pos_next = POS_START_A;
                end
            end
            default:
            begin
                if (pos_reg == ck_hi_pos)
                begin
                    ck_hi_next = rx_byte;
                    pos_next   = pos_reg + 5'd1;
                end
                else if (pos_reg == ck_lo_pos)
                begin
                    status.frame_end = 1'b1;
                    pos_next         = POS_START_A;
                end
                else
                begin
                    sum_next = sum_plus;
                    store_we = (pidx < POS_W'(PAYLOAD_BYTES));
                    pos_next = pos_reg + 5'd1;
                end
            end
        endcase
    end

    // Parser registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_START_A;
            sum_reg    <= '0;
            len_hi_reg <= '0;
            long_reg   <= 1'b0;
            ck_hi_reg  <= '0;
        end
        else if (cmd.byte_accept)
        begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            len_hi_reg <= len_hi_next;
            long_reg   <= long_next;
            ck_hi_reg  <= ck_hi_next;
        end
    end

    // Store valid bits: an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            even_vld_reg <= '0;
            odd_vld_reg  <= '0;
        end
        else if (cmd.byte_accept && store_we)
        begin
            if (pidx[0])
            begin
                odd_vld_reg[store_addr] <= 1'b1;
            end
            else
            begin
                even_vld_reg[store_addr] <= 1'b1;
            end
        end
    end

    // Store write port.
    always_ff @(posedge clk)
    begin
        if (cmd.byte_accept && store_we)
        begin
            if (pidx[0])
            begin
                odd_mem_reg[store_addr] <= rx_byte;
            end
            else
            begin
                even_mem_reg[store_addr] <= rx_byte;
            end
        end
    end

    // Store read port, registered.
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            even_rd_reg     <= even_mem_reg[word_reg];
            odd_rd_reg      <= odd_mem_reg[word_reg];
            even_rd_vld_reg <= even_vld_reg[word_reg];
            odd_rd_vld_reg  <= odd_vld_reg[word_reg];
        end
    end

    // Word counter for the read-out burst.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (cmd.word_clear)
        begin
            word_reg <= '0;
        end
        else if (cmd.word_inc)
        begin
            word_reg <= word_reg + WORD_W'(1);
        end
    end

    // Result beat: a measurement word or the checksum error item.
    always_comb
    begin
        if (cmd.err_sel)
        begin
            res.word_index = '0;
            res.word_value = '0;
            res.frame_ok   = 1'b0;
            res.last       = 1'b1;
        end
        else
        begin
            res.word_index = WORD_IDX_W'(word_reg);
            res.word_value = {even_rd_vld_reg ? even_rd_reg : 8'h00,
                              odd_rd_vld_reg  ? odd_rd_reg  : 8'h00};
            res.frame_ok   = 1'b1;
            res.last       = status.last_word;
        end
    end

endmodule

// ===== rtl/particle_sensor_frame_parser_unit.sv =====
// Top level of the particle sensor serial frame parser.
//
// The parser takes one received byte per beat on rx and looks for frames that open with
// 0x42 0x4D, carry a big-endian length of 20 or 28, the payload and a big-endian checksum
// equal to the 16-bit wrapping sum of all earlier frame bytes. While receiving, a byte is
// taken every cycle. After the last checksum byte the parser stops taking bytes and either
// sends the twelve big-endian measurement words on tx (word 11 marked last), each word read
// from the registered payload store before it is shown, or one error beat (frame_ok low,
// last high) when the checksum does not match. A short frame leaves words 9 to 11 at
// whatever an earlier frame stored; after reset they read as zero.
module particle_sensor_frame_parser_unit
    import psfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    psfp_byte_if.sink   rx,
    psfp_word_if.source tx
);

    cmd_t    cmd;
    status_t status;
    result_t res;

    psfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .out_valid (tx.valid),
        .out_ready (tx.ready),
        .status    (status),
        .cmd       (cmd)
    );

    psfp_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (rx.rx_byte),
        .cmd     (cmd),
        .status  (status),
        .res     (res)
    );

    // Result beat fields.
    assign tx.word_index = res.word_index;
    assign tx.word_value = res.word_value;
    assign tx.frame_ok   = res.frame_ok;
    assign tx.last       = res.last;

    // Reception and read-out never overlap.
    assert property (@(posedge clk) disable iff (!rst_n) !(rx.ready && tx.valid))
        else $error("byte intake open while a result beat is offered");

    // An error beat is always a lone, zeroed, last beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && !tx.frame_ok) |-> (tx.last && (tx.word_value == 16'h0000)
                                        && (tx.word_index == 4'd0)))
        else $error("malformed checksum error beat");

    // Word numbers stay within the measurement set.
    assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid |-> (tx.word_index <= 4'd11))
        else $error("word index out of range");

    // After a non-final word is taken, the next word is fetched first.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.ready && !tx.last) |=> (!tx.valid && !rx.ready))
        else $error("read-out skipped the store fetch cycle");

endmodule

// ===== dv/psfp_frame_checker.sv =====
`timescale 1ns / 1ps
// Frame checker: predicts the parser's word beats and compares them with the tx channel.
module psfp_frame_checker
    import psfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    psfp_byte_if rx,
    psfp_word_if tx,
    output int   fail_count,
    output int   words_pending
);

    localparam int PAYLOAD_BYTES = 24;
    localparam int WORD_COUNT    = 12;
    localparam int PRINT_LIMIT   = 40;

    // Predicted parser state.
    logic [POS_W-1:0] byte_pos;
    logic [15:0]      run_sum;
    logic [15:0]      frame_len;
    logic [15:0]      rx_checksum;
    logic [7:0]       payload_mem [PAYLOAD_BYTES];

    // Word beats still owed by the parser, oldest first.
    result_t word_queue [$];

    // Prints one line per mismatch, up to a limit, and counts every one.
    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
        begin
            $display("[%0t] frame checker: %s", $realtime, what);
        end
    endtask

    // Advances the predicted parser by one received byte and queues any words it causes.
    task automatic parse_byte(input logic [7:0] b);
        logic [POS_W-1:0] pos_now;
        result_t          word;
        int               slot;
        int               k;
        pos_now  = byte_pos;
        byte_pos = pos_now + 1'b1;
        case (pos_now)
            POS_START_A:
            begin
                if (b != START_BYTE_A)
                begin
                    byte_pos = POS_START_A;
                end
                else
                begin
                    run_sum = 16'(b);
                end
            end
            POS_START_B:
            begin
                // A wrong second byte is consumed, not retried as a start byte.
                if (b != START_BYTE_B)
                begin
                    byte_pos = POS_START_A;
                end
                else
                begin
                    run_sum = run_sum + 16'(b);
                end
            end
            POS_LEN_HI:
            begin
                run_sum   = run_sum + 16'(b);
                frame_len = {b, 8'h00};
            end
            POS_LEN_LO:
            begin
                frame_len = frame_len | 16'(b);
                if (frame_len != {8'h00, LEN_SHORT} && frame_len != {8'h00, LEN_LONG})
                begin
                    byte_pos = POS_START_A;
                end
                else
                begin
                    run_sum = run_sum + 16'(b);
                end
            end
            default:
            begin
                if (int'(pos_now) == int'(frame_len) + 2)
                begin
                    rx_checksum = {b, 8'h00};
                end
                else if (int'(pos_now) == int'(frame_len) + 3)
                begin
                    rx_checksum = rx_checksum | 16'(b);
                    byte_pos    = POS_START_A;
                    if (run_sum == rx_checksum)
                    begin
                        for (k = 0; k < WORD_COUNT; k++)
                        begin
                            word.word_index = WORD_IDX_W'(k);
                            word.word_value = {payload_mem[2 * k], payload_mem[2 * k + 1]};
                            word.frame_ok   = 1'b1;
                            word.last       = (k == WORD_COUNT - 1);
                            word_queue.push_back(word);
                        end
                    end
                    else
                    begin
                        word      = '0;
                        word.last = 1'b1;
                        word_queue.push_back(word);
                    end
                end
                else
                begin
                    // Payload byte: summed always, stored only within the first 24.
                    run_sum = run_sum + 16'(b);
                    slot    = int'(pos_now) - int'(POS_PAYLOAD);
                    if (slot < PAYLOAD_BYTES)
                    begin
                        payload_mem[slot] = b;
                    end
                end
            end
        endcase
    endtask

    // Compares one word beat with the oldest queued prediction.
    task automatic check_word();
        result_t want;
        if (word_queue.size() == 0)
        begin
            report_mismatch($sformatf("word beat with none pending: index %0d value %h ok %b last %b",
                                      tx.word_index, tx.word_value, tx.frame_ok, tx.last));
        end
        else
        begin
            want = word_queue.pop_front();
            if (tx.word_index !== want.word_index)
            begin
                report_mismatch($sformatf("word_index %0d, predicted %0d",
                                          tx.word_index, want.word_index));
            end
            if (tx.word_value !== want.word_value)
            begin
                report_mismatch($sformatf("word_value %h, predicted %h (index %0d)",
                                          tx.word_value, want.word_value, want.word_index));
            end
            if (tx.frame_ok !== want.frame_ok)
            begin
                report_mismatch($sformatf("frame_ok %b, predicted %b (index %0d)",
                                          tx.frame_ok, want.frame_ok, want.word_index));
            end
            if (tx.last !== want.last)
            begin
                report_mismatch($sformatf("last %b, predicted %b (index %0d)",
                                          tx.last, want.last, want.word_index));
            end
        end
    endtask

    // Watch both channels; bytes are taken before words since a word never
    // leaves on the same edge as the byte that caused it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos    = POS_START_A;
            run_sum     = '0;
            frame_len   = '0;
            rx_checksum = '0;
            for (int i = 0; i < PAYLOAD_BYTES; i++)
            begin
                payload_mem[i] = '0;
            end
            word_queue.delete();
            fail_count    = 0;
            words_pending = 0;
        end
        else
        begin
            if (rx.valid === 1'b1 && rx.ready === 1'b1)
            begin
                parse_byte(rx.rx_byte);
            end
            if (tx.valid === 1'b1 && tx.ready === 1'b1)
            begin
                check_word();
            end
            words_pending = word_queue.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, serial byte frames with random gaps, tx stalls and the verdict.
module testbench;
    import psfp_pkg::*;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ONES,
        FILL_CHECKER
    } fill_t;

    localparam int FRAME_BYTES_TARGET = 230;
    localparam int DRAIN_CYCLES       = 50;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   words_pending;

    // Byte stream to send, with a flag per byte that asks for a full drain after it.
    logic [7:0] byte_stream [$];
    logic       drain_after [$];
    int         noise_count;
    int         gapless_run;

    psfp_byte_if rx();
    psfp_word_if tx();

    particle_sensor_frame_parser_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .tx    (tx)
    );

    psfp_frame_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx),
        .tx            (tx),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic push_byte(input logic [7:0] b);
        byte_stream.push_back(b);
        drain_after.push_back(1'b0);
    endtask

    task automatic mark_drain();
        drain_after[drain_after.size() - 1] = 1'b1;
    endtask

    // Appends a well-formed frame; a corrupted one carries a wrong checksum.
    task automatic add_frame(input logic long_frame, input fill_t fill, input logic corrupt);
        logic [7:0]  len_lo;
        logic [7:0]  b;
        logic [15:0] sum;
        logic [15:0] ck;
        int          n;
        int          i;
        len_lo = long_frame ? LEN_LONG : LEN_SHORT;
        n      = int'(len_lo) - 2;
        sum    = 16'(START_BYTE_A) + 16'(START_BYTE_B) + 16'(len_lo);
        push_byte(START_BYTE_A);
        push_byte(START_BYTE_B);
        push_byte(8'h00);
        push_byte(len_lo);
        for (i = 0; i < n; i++)
        begin
            case (fill)
                FILL_ONES:    b = 8'hFF;
                FILL_CHECKER: b = i[0] ? 8'h00 : 8'hFF;
                default:      b = 8'($urandom);
            endcase
            sum = sum + 16'(b);
            push_byte(b);
        end
        ck = corrupt ? (sum ^ 16'($urandom_range(1, 65535))) : sum;
        push_byte(ck[15:8]);
        push_byte(ck[7:0]);
    endtask

    // Appends a header that breaks at the second byte or at the length field.
    task automatic add_broken_header();
        logic [7:0] b;
        logic [7:0] hi;
        logic [7:0] lo;
        push_byte(START_BYTE_A);
        if ($urandom_range(0, 1) == 0)
        begin
            b = 8'($urandom);
            if (b == START_BYTE_B)
            begin
                b = 8'h00;
            end
            push_byte(b);
        end
        else
        begin
            hi = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            lo = 8'($urandom);
            if (hi != 8'h00 && $urandom_range(0, 1) == 0)
            begin
                // A valid low byte under a nonzero high byte must still be refused.
                lo = $urandom_range(0, 1) ? LEN_SHORT : LEN_LONG;
            end
            else if (hi == 8'h00 && (lo == LEN_SHORT || lo == LEN_LONG))
            begin
                lo = lo + 8'd1;
            end
            push_byte(START_BYTE_B);
            push_byte(hi);
            push_byte(lo);
        end
    endtask

    // Appends idle-line noise that never contains the first start byte.
    task automatic add_noise();
        logic [7:0] b;
        int         n;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            b = 8'($urandom);
            if (b == START_BYTE_A)
            begin
                b = 8'h00;
            end
            push_byte(b);
            noise_count++;
        end
    endtask

    task automatic build_stimulus();
        int pick;
        // Directed: dropped bytes, a wrong second byte, refused lengths.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(START_BYTE_A);
        push_byte(START_BYTE_A);
        push_byte(START_BYTE_B);
        push_byte(START_BYTE_A);
        push_byte(START_BYTE_B);
        push_byte(8'h01);
        push_byte(LEN_SHORT);
        push_byte(START_BYTE_A);
        push_byte(START_BYTE_B);
        push_byte(8'h00);
        push_byte(LEN_SHORT + 8'd1);
        // Short frame straight after reset: words 9 to 11 read zero.
        add_frame(1'b0, FILL_CHECKER, 1'b0);
        add_frame(1'b1, FILL_ONES, 1'b0);
        // Short frame after a long one: words 9 to 11 keep the old bytes.
        add_frame(1'b0, FILL_RANDOM, 1'b0);
        add_frame(1'b1, FILL_RANDOM, 1'b1);
        mark_drain();

        // Random: mostly good frames, some bad checksums, broken headers and noise.
        while (byte_stream.size() - noise_count < FRAME_BYTES_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                add_frame(1'($urandom_range(0, 1)), FILL_RANDOM, 1'b0);
            end
            else if (pick == 7)
            begin
                add_frame(1'($urandom_range(0, 1)), FILL_RANDOM, 1'b1);
            end
            else if (pick == 8)
            begin
                add_broken_header();
            end
            else
            begin
                add_noise();
            end
            if ($urandom_range(0, 7) == 0)
            begin
                mark_drain();
            end
        end
        mark_drain();
    endtask

    // Gap before the next byte: mostly none or short, a few long, with gapless stretches.
    function automatic int pick_gap();
        int roll;
        if (gapless_run > 0)
        begin
            gapless_run--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            gapless_run = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    // Byte sender and verdict.
    initial
    begin
        int idx;
        int gap;
        rst_n       <= 1'b0;
        rx.valid    <= 1'b0;
        rx.rx_byte  <= 8'h00;
        noise_count = 0;
        gapless_run = 0;
        build_stimulus();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (idx = 0; idx < byte_stream.size(); idx++)
        begin
            rx.valid   <= 1'b1;
            rx.rx_byte <= byte_stream[idx];
            @(posedge clk);
            while (rx.ready !== 1'b1)
            begin
                @(posedge clk);
            end
            if (drain_after[idx])
            begin
                // Hold off until every predicted word has left the parser.
                rx.valid <= 1'b0;
                @(negedge clk);
                while (words_pending != 0)
                begin
                    @(negedge clk);
                end
                @(posedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    rx.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && words_pending == 0)
        begin
            $display("particle_sensor_frame_parser_unit regression: pass");
        end
        else
        begin
            $display("particle_sensor_frame_parser_unit regression: fail");
        end
        $finish;
    end

    // Word receiver: ready runs and stalls, mostly short, some long, some long open stretches.
    initial
    begin
        int run_len;
        int stall_len;
        tx.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                    : $urandom_range(1, 6);
            stall_len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 25)
                                                    : $urandom_range(1, 2);
            tx.ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            tx.ready <= 1'b0;
            repeat (stall_len) @(posedge clk);
        end
    end

    // Watchdog.
    initial
    begin
        #1_000_000;
        $display("particle_sensor_frame_parser_unit regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/psfp_pkg.sv
rtl/psfp_byte_if.sv
rtl/psfp_word_if.sv
rtl/psfp_ctrl.sv
rtl/psfp_datapath.sv
rtl/particle_sensor_frame_parser_unit.sv
dv/psfp_frame_checker.sv
dv/testbench.sv
